### rtl/lpcd_pkg.sv
// Shared constants and types for the length-prefixed chunk deframer.
package lpcd_pkg;

	// Default width of the chunk length counter.
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	typedef logic [7:0] byte_t;

	// Framing characters.
	localparam byte_t CH_END   = 8'h24;  // '$'
	localparam byte_t CH_OPEN  = 8'h28;  // '('
	localparam byte_t CH_CLOSE = 8'h29;  // ')'
	localparam byte_t CH_ZERO  = 8'h30;  // '0'
	localparam byte_t CH_NINE  = 8'h39;  // '9'

	// Result kinds.
	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_END     = 1'b1
	} kind_t;

endpackage

### rtl/lpcd_byte_if.sv
// Valid/ready channel that carries one raw link byte per transaction.
interface lpcd_byte_if;
	import lpcd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);

endinterface

### rtl/lpcd_result_if.sv
// Valid/ready channel that carries one deframed result per transaction.
interface lpcd_result_if;
	import lpcd_pkg::*;

	logic  valid;
	logic  ready;
	logic  out_kind;
	byte_t payload_byte;

	modport source (output valid, output out_kind, output payload_byte, input ready);
	modport sink   (input valid, input out_kind, input payload_byte, output ready);

endinterface

### rtl/length_prefixed_chunk_deframer.sv
// Length-prefixed chunk deframer: turns a "(len)payload...$" byte stream into results.
//
// The block reads a byte stream made of chunks written as '(' plus a decimal
// length plus ')' followed by exactly that many payload bytes. Each payload
// byte comes out as a payload result, whatever its value, and a '$' seen
// outside a chunk comes out as an end-of-message result with a zero byte.
// Any other byte outside a chunk is dropped. The length is read like atoi:
// digits count until the first non-digit, and everything after that up to
// ')' is ignored; the length saturates at 2^COUNT_WIDTH - 1, and a zero or
// missing length gives a chunk without payload. The block takes one byte
// transaction per clock cycle while the result side keeps up. A byte that
// causes a result has it offered on the result channel from the clock edge
// after its transaction, unless a waiting result still holds the result
// register. The byte and its result pass the input register, which holds
// the accepted byte, and the result register, which holds the finished
// result; the parser state advances in the logic between them, so the
// input side keeps accepting while a result waits to be taken, and stalls
// only when both registers are full and the result channel is not ready.
module length_prefixed_chunk_deframer #(
	parameter int unsigned COUNT_WIDTH = lpcd_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	lpcd_byte_if.sink         link,
	lpcd_result_if.source     result
);
	import lpcd_pkg::*;

	// The length update needs room for count * 10 + 9 before saturation.
	localparam int unsigned WIDE_WIDTH = COUNT_WIDTH + 4;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_LENGTH  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} mode_t;

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;

	// Parser state.
	mode_t                  mode_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   digits_done_q;

	// Result register.
	logic  res_valid_q;
	kind_t res_kind_q;
	byte_t res_byte_q;

	// Next-state and result logic for the byte in the input register.
	mode_t                  mode_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   digits_done_d;
	logic                   emit;
	kind_t                  emit_kind;
	byte_t                  emit_byte;

	logic                   advance;
	logic                   is_digit;
	logic [WIDE_WIDTH-1:0]  count_wide;
	logic [WIDE_WIDTH-1:0]  count_next_wide;
	logic [COUNT_WIDTH-1:0] count_dec;

	// The stage moves when the result register is free or is emptied now.
	assign advance    = !res_valid_q || result.ready;
	assign link.ready = !valid_s1 || advance;

	assign is_digit   = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);

	// count * 10 as two shifts and an add, then the new digit.
	assign count_wide      = WIDE_WIDTH'(count_q);
	assign count_next_wide = (count_wide << 3) + (count_wide << 1)
		+ WIDE_WIDTH'(byte_s1[3:0]);
	assign count_dec       = (count_q != '0) ? count_q - 1'b1 : count_q;

	always_comb begin
		mode_d        = mode_q;
		count_d       = count_q;
		digits_done_d = digits_done_q;
		emit          = 1'b0;
		emit_kind     = KIND_PAYLOAD;
		emit_byte     = '0;
		case (mode_q)
			MODE_LENGTH: begin
				if (byte_s1 == CH_CLOSE) begin
					mode_d        = (count_q == '0) ? MODE_IDLE : MODE_PAYLOAD;
					digits_done_d = 1'b0;
				end else if (!digits_done_q && is_digit) begin
					// Saturate when the upper bits of the wide result are set.
					if (count_next_wide[WIDE_WIDTH-1:COUNT_WIDTH] != '0) begin
						count_d = COUNT_MAX;
					end else begin
						count_d = count_next_wide[COUNT_WIDTH-1:0];
					end
				end else begin
					digits_done_d = 1'b1;
				end
			end
			MODE_PAYLOAD: begin
				emit      = 1'b1;
				emit_kind = KIND_PAYLOAD;
				emit_byte = byte_s1;
				count_d   = count_dec;
				if (count_dec == '0) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (byte_s1 == CH_END) begin
					emit      = 1'b1;
					emit_kind = KIND_END;
				end else if (byte_s1 == CH_OPEN) begin
					mode_d        = MODE_LENGTH;
					count_d       = '0;
					digits_done_d = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			byte_s1       <= '0;
			mode_q        <= MODE_IDLE;
			count_q       <= '0;
			digits_done_q <= 1'b0;
			res_valid_q   <= 1'b0;
			res_kind_q    <= KIND_PAYLOAD;
			res_byte_q    <= '0;
		end else begin
			if (link.ready) begin
				valid_s1 <= link.valid;
				if (link.valid) begin
					byte_s1 <= link.in_byte;
				end
			end
			if (advance) begin
				res_valid_q <= valid_s1 && emit;
				if (valid_s1) begin
					mode_q        <= mode_d;
					count_q       <= count_d;
					digits_done_q <= digits_done_d;
					res_kind_q    <= emit_kind;
					res_byte_q    <= emit_byte;
				end
			end
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_kind     = res_kind_q;
	assign result.payload_byte = res_byte_q;

endmodule

### rtl/lpcd_checker.sv
// Port-level assertions for the chunk deframer and the bind that attaches them.
module lpcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_kind,
	input logic [7:0] res_byte
);
	import lpcd_pkg::*;

	// A pending result stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
	else $error("result withdrawn before its transaction");

	// A stalled result keeps its content.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_kind) && $stable(res_byte))
	else $error("stalled result changed");

	// An end-of-message result always carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_END) |-> (res_byte == '0))
	else $error("end-of-message result with nonzero byte");

	// A fresh result follows an input transaction through the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_valid && in_ready, 2))
	else $error("result appeared without a matching input transaction");

endmodule

bind length_prefixed_chunk_deframer lpcd_checker u_lpcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (link.valid),
	.in_ready  (link.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.out_kind),
	.res_byte  (result.payload_byte)
);

### test/length_prefixed_chunk_deframer_tb.sv
// Self-checking testbench for the length-prefixed chunk deframer.
module length_prefixed_chunk_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpcd_pkg::*;

	// The counter width is kept at the package default, so the saturating
	// length is 65535. The saturating chunk at the end of the run is only
	// partly sent, which is enough to tell saturation from wrap-around.
	localparam int unsigned CW = COUNT_WIDTH_DEF;
	localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 64'd1;

	// The block offers a result from the edge after its byte transaction, so
	// a short drain after the last expected result catches anything extra.
	localparam int unsigned DRAIN_CYCLES = 16;

	// Even a long run, with every byte transaction waiting out the longest
	// link gap and the longest result stall, stays well inside the limit.
	localparam int unsigned CYCLE_LIMIT = 400_000;

	localparam int unsigned RANDOM_ITEMS = 1000;

	// Payload bytes sent after the saturating length field.
	localparam int unsigned SAT_PAYLOAD = 200;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_LENGTH  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} chunk_mode_t;

	typedef struct packed {
		kind_t kind;
		byte_t data;
	} deframed_t;

	// A pinned note carries a result typed in by hand. It replaces the
	// predicted one for that byte, while the predictor still advances.
	typedef struct packed {
		logic      pinned;
		logic      yields;
		deframed_t want;
	} pin_note_t;

	typedef struct packed {
		byte_t     link_byte;
		pin_note_t note;
	} opening_row_t;

	localparam deframed_t NO_RESULT = '{KIND_PAYLOAD, 8'h00};
	localparam pin_note_t FREE_NOTE = '{1'b0, 1'b0, NO_RESULT};
	localparam pin_note_t PIN_NONE  = '{1'b1, 1'b0, NO_RESULT};
	localparam pin_note_t PIN_END   = '{1'b1, 1'b1, '{KIND_END, 8'h00}};

	// The opening rows walk the framing by hand: stray bytes right after
	// reset, an end marker, the byte extremes while idle, an empty "()"
	// chunk, a "(0)" chunk, a three-byte chunk whose payload is made of
	// framing characters and a zero byte, a length field that stops at a
	// letter, and a field with no leading digit at all.
	localparam opening_row_t OPENING_ROWS [27] = '{
		'{8'h78,    PIN_NONE},
		'{CH_END,   PIN_END},
		'{8'h00,    PIN_NONE},
		'{8'hFF,    PIN_NONE},
		'{CH_OPEN,  FREE_NOTE},
		'{CH_CLOSE, PIN_NONE},
		'{CH_END,   PIN_END},
		'{CH_OPEN,  FREE_NOTE},
		'{CH_ZERO,  FREE_NOTE},
		'{CH_CLOSE, PIN_NONE},
		'{CH_OPEN,  FREE_NOTE},
		'{8'h33,    FREE_NOTE},
		'{CH_CLOSE, FREE_NOTE},
		'{CH_END,   '{1'b1, 1'b1, '{KIND_PAYLOAD, CH_END}}},
		'{CH_OPEN,  '{1'b1, 1'b1, '{KIND_PAYLOAD, CH_OPEN}}},
		'{8'h00,    '{1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00}}},
		'{CH_OPEN,  FREE_NOTE},
		'{8'h31,    FREE_NOTE},
		'{8'h61,    FREE_NOTE},
		'{CH_NINE,  FREE_NOTE},
		'{CH_CLOSE, FREE_NOTE},
		'{8'hFF,    FREE_NOTE},
		'{CH_OPEN,  FREE_NOTE},
		'{8'h20,    FREE_NOTE},
		'{8'h35,    FREE_NOTE},
		'{CH_CLOSE, FREE_NOTE},
		'{CH_END,   FREE_NOTE}
	};

	logic clk;
	logic arst_n;

	lpcd_byte_if   link_ch ();
	lpcd_result_if res_ch ();

	length_prefixed_chunk_deframer #(
		.COUNT_WIDTH(CW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link_ch),
		.result (res_ch)
	);

	// Shadow of the parser state, advanced once per accepted byte.
	chunk_mode_t    link_mode   = MODE_IDLE;
	logic [CW-1:0]  chunk_count = '0;
	logic           digits_over = 1'b0;

	deframed_t      deframed_q [$];
	pin_note_t      pin_notes [$];

	int unsigned    mismatches  = 0;
	int unsigned    link_items  = 0;
	int unsigned    bytes_seen  = 0;
	int unsigned    cycle_count = 0;
	int unsigned    link_calm   = 0;
	int unsigned    stall_left  = 0;
	int unsigned    result_calm = 0;
	bit             quiet_tail  = 1'b0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Advance the shadow parser by one link byte. Returns 1 when the byte
	// produces a result, which is then left in got.
	function automatic bit deframe_byte(input byte_t value, output deframed_t got);
		longint unsigned grown;
		got = NO_RESULT;
		case (link_mode)
			MODE_LENGTH: begin
				if (value == CH_CLOSE) begin
					link_mode   = (chunk_count == 0) ? MODE_IDLE : MODE_PAYLOAD;
					digits_over = 1'b0;
				end else if (!digits_over && value >= CH_ZERO && value <= CH_NINE) begin
					grown = 64'(chunk_count) * 64'd10 + 64'(value) - 64'(CH_ZERO);
					chunk_count = (grown > COUNT_MAX) ? '1 : grown[CW-1:0];
				end else begin
					digits_over = 1'b1;
				end
				return 1'b0;
			end
			MODE_PAYLOAD: begin
				got = '{KIND_PAYLOAD, value};
				if (chunk_count != 0)
					chunk_count = chunk_count - 1'b1;
				if (chunk_count == 0)
					link_mode = MODE_IDLE;
				return 1'b1;
			end
			default: begin
				// The unused fourth mode behaves as idle.
				link_mode = MODE_IDLE;
				if (value == CH_END) begin
					got = '{KIND_END, 8'h00};
					return 1'b1;
				end
				if (value == CH_OPEN) begin
					link_mode   = MODE_LENGTH;
					chunk_count = '0;
					digits_over = 1'b0;
				end
				return 1'b0;
			end
		endcase
	endfunction

	// A payload byte leans toward the framing characters and the extremes,
	// since the block must pass all of them through untouched.
	function automatic byte_t pick_payload();
		case ($urandom_range(0, 15))
			0: return CH_END;
			1: return CH_OPEN;
			2: return CH_CLOSE;
			3: return 8'h00;
			4: return 8'hFF;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	// A byte that ends the digit run without closing the field.
	function automatic byte_t pick_junk();
		byte_t value;
		case ($urandom_range(0, 7))
			0: value = CH_OPEN;
			1: value = CH_END;
			2: value = 8'h2D;
			3: value = 8'h2B;
			4: value = 8'h20;
			default: begin
				do
					value = byte_t'($urandom_range(0, 255));
				while (value == CH_CLOSE || (value >= CH_ZERO && value <= CH_NINE));
			end
		endcase
		return value;
	endfunction

	// Mostly short chunks, some medium ones, and a few of a few hundred bytes.
	function automatic int unsigned pick_length();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return $urandom_range(0, 12);
		if (pick < 18)
			return $urandom_range(13, 40);
		return $urandom_range(41, 300);
	endfunction

	// Offer one byte on the link and hold it until the transaction happens.
	// A random gap may come first, unless the run is in a calm stretch or in
	// its final part.
	task automatic drive_byte(input byte_t value, input pin_note_t note);
		int unsigned gap;
		gap = 0;
		if (!quiet_tail) begin
			if (link_calm != 0)
				link_calm--;
			else if ($urandom_range(0, 7) == 0)
				gap = $urandom_range(1, 18);
			else if ($urandom_range(0, 39) == 0)
				link_calm = $urandom_range(20, 100);
		end
		if (gap != 0) begin
			link_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin_notes.push_back(note);
		link_ch.valid   <= 1'b1;
		link_ch.in_byte <= value;
		link_items++;
		@(posedge clk);
		while (!link_ch.ready) @(posedge clk);
	endtask

	task automatic drive_free(input byte_t value);
		drive_byte(value, FREE_NOTE);
	endtask

	// Send one chunk. Most are well formed, with plain or zero-padded
	// lengths; some carry junk after the digits, some have no leading digit,
	// some never close the length field, and some stop short of their payload.
	task automatic send_chunk(input int unsigned len);
		string       digits;
		int unsigned style;
		int unsigned sent_len;
		style = $urandom_range(0, 19);
		drive_free(CH_OPEN);
		if (style == 0) begin
			// A field that starts with a non-digit reads as zero length.
			len = 0;
			drive_free(pick_junk());
		end else begin
			digits = $sformatf("%0d", len);
			if (style == 1)
				digits = {"00", digits};
			if (len == 0 && $urandom_range(0, 1) == 0)
				digits = "";
			for (int i = 0; i < digits.len(); i++)
				drive_free(byte_t'(digits[i]));
			if (style == 2)
				drive_free(pick_junk());
		end
		if (style <= 2) begin
			// Once the digit run is over, even digits are ignored up to ')'.
			repeat ($urandom_range(0, 3)) begin
				byte_t tail;
				do
					tail = byte_t'($urandom_range(0, 255));
				while (tail == CH_CLOSE);
				drive_free(tail);
			end
		end
		if (style == 3)
			return;
		drive_free(CH_CLOSE);
		sent_len = (style == 4) ? $urandom_range(0, len) : len;
		repeat (sent_len) drive_free(pick_payload());
	endtask

	// Every accepted byte advances the shadow parser; every accepted result
	// is compared with the oldest expectation. Both sides are sampled at the
	// rising edge, before the edge's own updates land.
	always @(posedge clk) begin : scoreboard
		pin_note_t note;
		deframed_t predicted;
		deframed_t got;
		deframed_t want;
		bit        produced;
		if (arst_n) begin
			if (link_ch.valid && link_ch.ready) begin
				note     = pin_notes.pop_front();
				produced = deframe_byte(link_ch.in_byte, predicted);
				bytes_seen++;
				if (note.pinned) begin
					if (note.yields)
						deframed_q.push_back(note.want);
				end else if (produced) begin
					deframed_q.push_back(predicted);
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				got = deframed_t'({res_ch.out_kind, res_ch.payload_byte});
				if (deframed_q.size() == 0) begin
					$display("%0t: result with none expected, actual kind %0d byte 0x%02h",
						$time, got.kind, got.data);
					mismatches++;
				end else begin
					want = deframed_q.pop_front();
					if (got.kind !== want.kind || got.data !== want.data) begin
						$display("%0t: expected kind %0d byte 0x%02h, actual kind %0d byte 0x%02h",
							$time, want.kind, want.data, got.kind, got.data);
						mismatches++;
					end
				end
			end
		end
	end

	// The result side stalls in random bursts, with calm stretches between,
	// and stays ready throughout the final part of the run.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			if (!quiet_tail) begin
				if (result_calm != 0)
					result_calm--;
				else if ($urandom_range(0, 11) == 0)
					stall_left = $urandom_range(1, 18);
				else if ($urandom_range(0, 59) == 0)
					result_calm = $urandom_range(30, 150);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned random_goal;
		string       sat_digits;
		arst_n          = 1'b0;
		link_ch.valid   = 1'b0;
		link_ch.in_byte = 8'h00;
		res_ch.ready    = 1'b0;
		sat_digits      = "65536";
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_ROWS[i])
			drive_byte(OPENING_ROWS[i].link_byte, OPENING_ROWS[i].note);

		// Random traffic: mostly messages of a few chunks ended by '$', with
		// bursts of raw noise between them.
		random_goal = link_items + RANDOM_ITEMS;
		while (link_items < random_goal) begin
			if (link_items + 100 >= random_goal)
				quiet_tail = 1'b1;
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 6))
					drive_free(byte_t'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_chunk(pick_length());
				drive_free(CH_END);
			end
		end

		// Close any open length field and drain any open chunk, so that the
		// saturating chunk starts from idle.
		wait (bytes_seen == link_items);
		while (link_mode != MODE_IDLE) begin
			drive_free(CH_CLOSE);
			wait (bytes_seen == link_items);
		end

		// One chunk whose length field overflows the counter. A counter that
		// wrapped instead of saturating would read zero after "65536" and
		// treat the payload that follows as framing.
		drive_free(CH_OPEN);
		for (int i = 0; i < sat_digits.len(); i++)
			drive_free(byte_t'(sat_digits[i]));
		repeat ($urandom_range(0, 2))
			drive_free(byte_t'($urandom_range(CH_ZERO, CH_NINE)));
		drive_free(CH_CLOSE);
		repeat (SAT_PAYLOAD) drive_free(pick_payload());

		link_ch.valid <= 1'b0;
		@(posedge clk);
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
